[hdl/assert_macros.svh]
// Assertion helpers, all checks sampled on clk and held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds at every edge outside reset.
`define SFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on the next edge.
`define SFB_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

[hdl/sfb_pkg.sv]
`default_nettype none
package sfb_pkg;

  localparam int BYTE_BITS   = 8;
  localparam int NUM_CHAN    = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int DATA_BYTES  = NUM_CHAN * SAMPLE_BITS / BYTE_BITS;
  localparam int FRAME_BYTES = DATA_BYTES + 2;
  localparam int IDX_BITS    = $clog2(FRAME_BYTES);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Byte positions in the frame
  localparam logic [IDX_BITS-1:0] IDX_FIRST  = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] IDX_CRC_LO = IDX_BITS'(DATA_BYTES);
  localparam logic [IDX_BITS-1:0] IDX_CRC_HI = IDX_BITS'(DATA_BYTES + 1);

  typedef logic [DATA_BYTES-1:0][BYTE_BITS-1:0] sample_bytes_t;

  // Held input word, handed to the serializer
  typedef struct packed {
    logic          valid;
    sample_bytes_t bytes;
  } held_word_t;

  // CRC-16/MODBUS update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [BYTE_BITS-1:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < BYTE_BITS; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[hdl/sfb_in_reg.sv]
`default_nettype none
module sfb_in_reg
  import sfb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output      logic          s_tready,
  input  wire sample_bytes_t s_tdata,
  input  wire logic          load,
  output      held_word_t    held
);

  logic          full;
  sample_bytes_t bytes;

  assign s_tready   = !full || load;
  assign held.valid = full;
  assign held.bytes = bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      full <= 1'b1;
    end else if (load) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      bytes <= s_tdata;
    end
  end

endmodule
`default_nettype wire

[hdl/sfb_serializer.sv]
`default_nettype none
module sfb_serializer
  import sfb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire held_word_t           held,
  output      logic                 load,
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  output      logic [BYTE_BITS-1:0] m_tdata,
  output      logic                 m_tlast
);

  logic                 busy;
  logic [IDX_BITS-1:0]  idx;
  sample_bytes_t        bytes;
  logic [15:0]          crc;
  logic                 out_valid;
  logic [BYTE_BITS-1:0] out_byte;
  logic                 out_last;

  logic                 out_free;
  logic                 step;
  logic                 finish;
  logic                 in_data;
  logic [BYTE_BITS-1:0] cur_byte;

  assign out_free = !out_valid || m_tready;
  assign step     = busy && out_free;
  assign finish   = step && (idx == IDX_CRC_HI);
  assign load     = held.valid && (!busy || finish);
  assign in_data  = idx < IDX_CRC_LO;

  always_comb begin
    if (in_data) begin
      cur_byte = bytes[idx[$clog2(DATA_BYTES)-1:0]];
    end else if (idx == IDX_CRC_LO) begin
      cur_byte = crc[7:0];
    end else begin
      cur_byte = crc[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= IDX_FIRST;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= IDX_FIRST;
    end else if (finish) begin
      busy <= 1'b0;
    end else if (step) begin
      idx <= idx + IDX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= held.bytes;
      crc   <= CRC_INIT;
    end else if (step && in_data) begin
      crc <= crc_byte(crc, cur_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte <= cur_byte;
      out_last <= finish;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;

endmodule
`default_nettype wire

[hdl/scope_sample_frame_builder_top.sv]
// Channel | Dir | Width | Contents
// s_axis  | in  | 64    | tdata: chan_a[15:0], chan_b[31:16], chan_c[47:32], chan_d[63:48]
// m_axis  | out | 8     | tdata: frame_byte; tlast: last_byte (CRC high byte)
//
// Each input word becomes a 10-byte frame: samples low byte first, then CRC-16/MODBUS.
// One output word per cycle while m_tready stays high; the output port sets the rate.
// A held input register takes the next word while the current frame is still going out.
// Frames leave back to back when m_tready stays high and the next word is already held.
// rst is synchronous, active high; it empties both the input and output registers.
// Stalls on m_tready freeze the frame position; s_tready is low while the held word waits.
`default_nettype none
`include "assert_macros.svh"
module scope_sample_frame_builder_top
  import sfb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  // chan_a [15:0], chan_b [31:16], chan_c [47:32], chan_d [63:48]
  input  wire logic [63:0]          s_tdata,
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  // frame_byte [7:0]
  output      logic [BYTE_BITS-1:0] m_tdata,
  // last_byte
  output      logic                 m_tlast
);

  held_word_t held;
  logic       load;

  // Input side: one-deep holding register.
  sfb_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (sample_bytes_t'(s_tdata)),
    .load     (load),
    .held     (held)
  );

  // Byte sequencer with running CRC and output register.
  sfb_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .held     (held),
    .load     (load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Count of output words within the current frame, for checking only.
  logic [IDX_BITS-1:0] out_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= IDX_FIRST;
    end else if (m_tvalid && m_tready) begin
      out_cnt <= m_tlast ? IDX_FIRST : out_cnt + IDX_BITS'(1);
    end
  end

  `SFB_ASSERT(a_last_on_tenth, !m_tvalid || (m_tlast == (out_cnt == IDX_CRC_HI)), "tlast out of place")
  `SFB_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, held.valid, "accepted word not held")
  `SFB_ASSERT_NEXT(a_hold_keeps, held.valid && !load, held.valid && $stable(held.bytes), "held word lost")

endmodule
`default_nettype wire
